// File: sv/calendar_date_advance_macros.svh
// Assertion helpers shared by the date-advance modules.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef CALENDAR_DATE_ADVANCE_MACROS_SVH
`define CALENDAR_DATE_ADVANCE_MACROS_SVH

// Same-cycle implication.
`define CDA_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define CDA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/cda_pkg.sv
`default_nettype none
package cda_pkg;

    localparam int YEAR_BITS  = 16;
    localparam int SUM_W      = ((YEAR_BITS > 16) ? YEAR_BITS : 16) + 1;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 16;
    localparam int NDAYS_W    = 16;
    localparam int NMONTHS_W  = 12;
    localparam int NYEARS_W   = 16;

    localparam int M400_W     = 9;
    localparam int CYCLE_400  = 400;

    // ceil(2^25 / 400): floor(y * RECIP_400 / 2^25) equals y / 400 for every 16-bit year
    localparam int                 RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_400   = 17'd83887;
    localparam int                 RECIP_SHIFT = 25;
    localparam int                 QUOT_W      = 8;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_DAYS,
        S_MONTHS,
        S_YEARS
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic day_step;
        logic month_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic mod_last;
        logic days_zero;
        logic months_zero;
    } t_sts;

    // Leap year from the year taken modulo 400.
    function automatic logic is_leap(input logic [M400_W-1:0] m400);
        logic div4;
        logic cent;
        div4 = (m400[1:0] == 2'd0);
        cent = (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
        return div4 && !cent;
    endfunction

    // Out-of-range month codes count as 31-day months.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// File: sv/cda_ctrl.sv
`default_nettype none
`include "calendar_date_advance_macros.svh"
module cda_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire cda_pkg::t_sts i_sts,
    output cda_pkg::t_cmd      o_cmd
);
    import cda_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MOD;
            end
            S_MOD: begin
                if (i_sts.mod_last) n_state = S_DAYS;
            end
            S_DAYS: begin
                if (i_sts.days_zero) n_state = S_MONTHS;
            end
            S_MONTHS: begin
                if (i_sts.months_zero) n_state = S_YEARS;
            end
            S_YEARS: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MOD:    o_cmd.mod_step   = 1'b1;
            S_DAYS:   o_cmd.day_step   = !i_sts.days_zero;
            S_MONTHS: o_cmd.month_step = !i_sts.months_zero;
            S_YEARS:  o_cmd.load_out   = slot_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result register empties when taken, refills on load_out.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `CDA_ASSERT_NOW(a_no_result_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten before taken")
    `CDA_ASSERT_NEXT(a_days_hold, r_state == S_DAYS && !i_sts.days_zero, r_state == S_DAYS, "left day loop early")
    `CDA_ASSERT_NEXT(a_accept_starts_mod, o_cmd.load, r_state == S_MOD, "accepted item did not start")

endmodule
`default_nettype wire

// File: sv/cda_dpath.sv
`default_nettype none
`include "calendar_date_advance_macros.svh"
module cda_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cda_pkg::t_cmd                     i_cmd,
    output cda_pkg::t_sts                          o_sts,
    input  wire logic [cda_pkg::DAY_W-1:0]         i_start_day,
    input  wire logic [cda_pkg::MONTH_W-1:0]       i_start_month,
    input  wire logic [cda_pkg::YEAR_W-1:0]        i_start_year,
    input  wire logic [cda_pkg::NDAYS_W-1:0]       i_add_days,
    input  wire logic [cda_pkg::NMONTHS_W-1:0]     i_add_months,
    input  wire logic [cda_pkg::NYEARS_W-1:0]      i_add_years,
    output logic      [cda_pkg::DAY_W-1:0]         o_result_day,
    output logic      [cda_pkg::MONTH_W-1:0]       o_result_month,
    output logic      [cda_pkg::YEAR_W-1:0]        o_result_year,
    output logic                                   o_year_overflow
);
    import cda_pkg::*;

    logic [DAY_W-1:0]      r_day,         n_day;
    logic [MONTH_W-1:0]    r_month,       n_month;
    logic [YEAR_BITS-1:0]  r_year,        n_year;
    logic [NDAYS_W-1:0]    r_days_left,   n_days_left;
    logic [NMONTHS_W-1:0]  r_months_left, n_months_left;
    logic [NYEARS_W-1:0]   r_add_years,   n_add_years;
    logic [M400_W-1:0]     r_m400,        n_m400;
    logic [QUOT_W-1:0]     r_quot,        n_quot;
    logic                  r_mod_phase,   n_mod_phase;
    logic                  r_ovf,         n_ovf;

    logic [DAY_W-1:0]      r_res_day;
    logic [MONTH_W-1:0]    r_res_month;
    logic [YEAR_W-1:0]     r_res_year;
    logic                  r_res_ovf;

    logic [YEAR_W-1:0]         year_in;
    logic [YEAR_W+RECIP_W-1:0] year_prod;
    logic [YEAR_W-1:0]         year_rem;
    logic [DAY_W:0]        day_p1;
    logic [MONTH_W:0]      month_p1;
    logic [DAY_W-1:0]      cur_len;
    logic                  day_roll;
    logic                  year_full;
    logic [YEAR_BITS-1:0]  year_p1;
    logic [M400_W-1:0]     m400_p1;
    logic [SUM_W-1:0]      year_sum;
    logic [YEAR_BITS-1:0]  year_final;

    // year mod 400: quotient by reciprocal multiply, then remainder on the next cycle
    assign year_in   = YEAR_W'(r_year);
    assign year_prod = (YEAR_W + RECIP_W)'(year_in) * (YEAR_W + RECIP_W)'(RECIP_400);
    assign year_rem  = year_in - YEAR_W'(r_quot) * YEAR_W'(CYCLE_400);
    assign day_p1    = {1'b0, r_day} + 6'd1;
    assign month_p1  = {1'b0, r_month} + 5'd1;
    assign cur_len   = month_len(r_month, is_leap(r_m400));
    assign day_roll  = day_p1 > {1'b0, cur_len};
    assign year_full = (r_year == '1);
    assign year_p1   = r_year + YEAR_BITS'(1);
    assign m400_p1   = (r_m400 == M400_W'(CYCLE_400 - 1)) ? '0 : r_m400 + M400_W'(1);
    assign year_sum  = SUM_W'(r_year) + SUM_W'(r_add_years);
    assign year_final = year_sum[YEAR_BITS-1:0];

    always_comb begin
        n_day         = r_day;
        n_month       = r_month;
        n_year        = r_year;
        n_days_left   = r_days_left;
        n_months_left = r_months_left;
        n_add_years   = r_add_years;
        n_m400        = r_m400;
        n_quot        = r_quot;
        n_mod_phase   = r_mod_phase;
        n_ovf         = r_ovf;
        if (i_cmd.load) begin
            n_day         = i_start_day;
            n_month       = i_start_month;
            n_year        = YEAR_BITS'(i_start_year);
            n_days_left   = i_add_days;
            n_months_left = i_add_months;
            n_add_years   = i_add_years;
            n_m400        = '0;
            n_mod_phase   = 1'b0;
            n_ovf         = 1'b0;
        end else if (i_cmd.mod_step) begin
            if (!r_mod_phase) begin
                n_quot      = year_prod[RECIP_SHIFT +: QUOT_W];
                n_mod_phase = 1'b1;
            end else begin
                n_m400 = year_rem[M400_W-1:0];
            end
        end else if (i_cmd.day_step) begin
            n_days_left = r_days_left - NDAYS_W'(1);
            if (day_roll) begin
                n_day = DAY_W'(1);
                if (r_month inside {[MONTH_JAN:MONTH_NOV]}) begin
                    n_month = day_p1 > 6'd0 ? month_p1[MONTH_W-1:0] : r_month;
                end else begin
                    n_month = MONTH_JAN;
                    if (year_full) begin
                        n_year = '0;
                        n_m400 = '0;
                        n_ovf  = 1'b1;
                    end else begin
                        n_year = year_p1;
                        n_m400 = m400_p1;
                    end
                end
            end else begin
                n_day = day_p1[DAY_W-1:0];
            end
        end else if (i_cmd.month_step) begin
            n_months_left = r_months_left - NMONTHS_W'(1);
            if (month_p1 > {1'b0, MONTH_DEC}) begin
                n_month = MONTH_JAN;
                if (year_full) begin
                    n_year = '0;
                    n_m400 = '0;
                    n_ovf  = 1'b1;
                end else begin
                    n_year = year_p1;
                    n_m400 = m400_p1;
                end
            end else begin
                n_month = month_p1[MONTH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_day         <= n_day;
        r_month       <= n_month;
        r_year        <= n_year;
        r_days_left   <= n_days_left;
        r_months_left <= n_months_left;
        r_add_years   <= n_add_years;
        r_m400        <= n_m400;
        r_quot        <= n_quot;
        r_mod_phase   <= n_mod_phase;
        r_ovf         <= n_ovf;
        if (i_cmd.load_out) begin
            r_res_day   <= r_day;
            r_res_month <= r_month;
            r_res_year  <= YEAR_W'(year_final);
            r_res_ovf   <= r_ovf | (year_sum[SUM_W-1:YEAR_BITS] != '0);
        end
    end

    assign o_sts.mod_last    = r_mod_phase;
    assign o_sts.days_zero   = (r_days_left == '0);
    assign o_sts.months_zero = (r_months_left == '0);

    assign o_result_day    = r_res_day;
    assign o_result_month  = r_res_month;
    assign o_result_year   = r_res_year;
    assign o_year_overflow = r_res_ovf;

    `CDA_ASSERT_NEXT(a_m400_range, i_cmd.mod_step, r_m400 < M400_W'(CYCLE_400), "year mod 400 out of range")
    `CDA_ASSERT_NEXT(a_day_nonzero, i_cmd.day_step, r_day != '0, "day zero after a day step")
    `CDA_ASSERT_NEXT(a_month_valid, i_cmd.month_step, r_month >= MONTH_JAN && r_month <= MONTH_DEC, "month out of range after a month step")

endmodule
`default_nettype wire

// File: sv/calendar_date_advance.sv
// Channel   Dir  Width  Contents
// s_axis    in   72     start date and the three amounts
// m_axis    out  32     resulting date and year overflow flag
//
// Per item, the year is reduced modulo 400 by a reciprocal multiply, then the day
// and month loops each advance one step per cycle in the shared datapath, and the
// years are added as the result is registered.
// Reset (synchronous, active low) returns the controller to idle and empties the
// result register. A stalled result waits in its register while the next item
// is accepted; the final step holds until that register frees.
`default_nettype none
module calendar_date_advance (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [4:0] start_day, [8:5] start_month, [24:9] start_year, [40:25] add_days,
    // [52:41] add_months, [68:53] add_years, [71:69] zero
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [4:0] result_day, [8:5] result_month, [24:9] result_year,
    // [25] year_overflow, [31:26] zero
    output logic [31:0]      o_m_axis_tdata
);
    import cda_pkg::*;

    t_cmd                 cmd;
    t_sts                 sts;
    logic [DAY_W-1:0]     result_day;
    logic [MONTH_W-1:0]   result_month;
    logic [YEAR_W-1:0]    result_year;
    logic                 year_overflow;

    cda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cda_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_start_day     (i_s_axis_tdata[4:0]),
        .i_start_month   (i_s_axis_tdata[8:5]),
        .i_start_year    (i_s_axis_tdata[24:9]),
        .i_add_days      (i_s_axis_tdata[40:25]),
        .i_add_months    (i_s_axis_tdata[52:41]),
        .i_add_years     (i_s_axis_tdata[68:53]),
        .o_result_day    (result_day),
        .o_result_month  (result_month),
        .o_result_year   (result_year),
        .o_year_overflow (year_overflow)
    );

    assign o_m_axis_tdata = {6'd0, year_overflow, result_year, result_month, result_day};

endmodule
`default_nettype wire

// File: dv/cda_checker.sv
`timescale 1ns / 1ps
module cda_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [4:0] start_day, [8:5] start_month, [24:9] start_year, [40:25] add_days,
    // [52:41] add_months, [68:53] add_years, [71:69] zero
    input  logic [71:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [4:0] result_day, [8:5] result_month, [24:9] result_year,
    // [25] year_overflow, [31:26] zero
    input  logic [31:0] i_m_tdata,
    output int          o_mismatch_count,
    output int          o_dates_pending
);
    import cda_pkg::*;

    localparam int YEAR_TOP   = (1 << YEAR_W) - 1;
    localparam int PRINT_CAP  = 60;

    // Declared MSB first so a cast of the result beat lines up.
    typedef struct packed {
        logic                 ovf;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
    } t_date;

    t_date expected_dates[$];
    int    mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % CYCLE_400 == 0);
    endfunction

    // Out-of-range month codes count as 31 days.
    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB)
            return leap_year(y) ? 29 : 28;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return 30;
        return 31;
    endfunction

    function automatic t_date advance_date(input logic [71:0] req);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned ndays;
        int unsigned nmonths;
        int unsigned nyears;
        int unsigned i;
        bit          ovf;
        t_date       res;
        day     = req[4:0];
        month   = req[8:5];
        year    = req[24:9];
        ndays   = req[40:25];
        nmonths = req[52:41];
        nyears  = req[68:53];
        ovf     = 1'b0;
        for (i = 0; i < ndays; i++) begin
            day++;
            if (day > days_in_month(month, year)) begin
                day = 1;
                if (month >= MONTH_JAN && month < MONTH_DEC) begin
                    month++;
                end else begin
                    month = MONTH_JAN;
                    if (year == YEAR_TOP) begin
                        ovf  = 1'b1;
                        year = 0;
                    end else begin
                        year++;
                    end
                end
            end
        end
        for (i = 0; i < nmonths; i++) begin
            month++;
            if (month > MONTH_DEC) begin
                month = MONTH_JAN;
                if (year == YEAR_TOP) begin
                    ovf  = 1'b1;
                    year = 0;
                end else begin
                    year++;
                end
            end
        end
        year = year + nyears;
        if (year > YEAR_TOP) begin
            ovf  = 1'b1;
            year = year & YEAR_TOP;
        end
        res.day   = day[DAY_W-1:0];
        res.month = month[MONTH_W-1:0];
        res.year  = year[YEAR_W-1:0];
        res.ovf   = ovf;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] date mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_date want;
        t_date got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                expected_dates.push_back(advance_date(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = t_date'(i_m_tdata[25:0]);
                if (expected_dates.size() == 0) begin
                    flag_mismatch($sformatf("result beat 0x%08h with no date pending",
                                            i_m_tdata));
                end else begin
                    want = expected_dates.pop_front();
                    if (got.day !== want.day)
                        flag_mismatch($sformatf("day got %0d want %0d", got.day, want.day));
                    if (got.month !== want.month)
                        flag_mismatch($sformatf("month got %0d want %0d",
                                                got.month, want.month));
                    if (got.year !== want.year)
                        flag_mismatch($sformatf("year got %0d want %0d", got.year, want.year));
                    if (got.ovf !== want.ovf)
                        flag_mismatch($sformatf("overflow got %b want %b", got.ovf, want.ovf));
                    if (i_m_tdata[31:26] !== 6'd0)
                        flag_mismatch($sformatf("pad bits got 0x%02h", i_m_tdata[31:26]));
                end
            end
            o_dates_pending <= expected_dates.size();
        end else begin
            o_dates_pending <= 0;
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import cda_pkg::*;

    localparam int RANDOM_ITEMS   = 1030;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int TAIL_CYCLES    = 40;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [71:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    int          mismatch_count;
    int          dates_pending;
    int          idle_cycles = 0;

    calendar_date_advance dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    cda_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_valid),
        .i_s_tready       (s_ready),
        .i_s_tdata        (s_data),
        .i_m_tvalid       (m_valid),
        .i_m_tready       (m_ready),
        .i_m_tdata        (m_data),
        .o_mismatch_count (mismatch_count),
        .o_dates_pending  (dates_pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [71:0] pack_request(input int unsigned day, input int unsigned month,
                                                 input int unsigned year, input int unsigned ndays,
                                                 input int unsigned nmonths,
                                                 input int unsigned nyears);
        return {3'b000, nyears[15:0], nmonths[11:0], ndays[15:0], year[15:0], month[3:0],
                day[4:0]};
    endfunction

    // Mostly valid dates; some noise dates; modest amounts, full-range rare but for years.
    function automatic logic [71:0] random_request();
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned ndays;
        int unsigned nmonths;
        int unsigned nyears;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            month = $urandom_range(1, 12);
            day   = $urandom_range(1, 28);
        end else if (pick < 95) begin
            month = $urandom_range(1, 12);
            day   = $urandom_range(28, 31);
        end else begin
            month = $urandom_range(0, 15);
            day   = $urandom_range(0, 31);
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
            year = $urandom_range(0, 65535);
        else if (pick < 70)
            year = $urandom_range(1582, 2500);
        else if (pick < 85)
            year = $urandom_range(65500, 65535);
        else
            year = $urandom_range(0, 500);
        pick = $urandom_range(0, 299);
        if (pick == 0)
            ndays = $urandom_range(0, 65535);
        else if (pick < 30)
            ndays = 0;
        else if (pick < 220)
            ndays = $urandom_range(0, 120);
        else
            ndays = $urandom_range(0, 800);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            nmonths = 0;
        else if (pick < 96)
            nmonths = $urandom_range(0, 24);
        else
            nmonths = $urandom_range(0, 4095);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            nyears = 0;
        else if (pick < 70)
            nyears = $urandom_range(0, 100);
        else
            nyears = $urandom_range(0, 65535);
        return pack_request(day, month, year, ndays, nmonths, nyears);
    endfunction

    // Leaves tvalid high after the beat; the caller drops it when it pauses.
    task automatic send_request(input logic [71:0] req);
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
    endtask

    task automatic drain_dates();
        s_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (dates_pending != 0);
    endtask

    // Receiver: switches at random between stall patterns.
    int rx_mode      = 0;
    int rx_left      = 0;
    int rx_stall     = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 3000);
        end
        rx_left--;
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= $urandom_range(0, 1);
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                        rx_stall = $urandom_range(5, 60);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int item_count;
        int burst_left;
        int gap_max;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing added: date passes through, odd month codes included
        send_request(pack_request(15, 6, 2024, 0, 0, 0));
        send_request(pack_request(0, 0, 1999, 0, 0, 0));
        send_request(pack_request(31, 15, 100, 0, 0, 0));
        // day zero and day beyond the month length
        send_request(pack_request(0, 5, 2023, 1, 0, 0));
        send_request(pack_request(31, 2, 2023, 1, 0, 0));
        // leap rules: 400 rule, century, plain, year zero
        send_request(pack_request(28, 2, 2000, 1, 0, 0));
        send_request(pack_request(28, 2, 1900, 1, 0, 0));
        send_request(pack_request(28, 2, 2024, 2, 0, 0));
        send_request(pack_request(29, 2, 0, 1, 0, 0));
        // year end, wrap of the year register
        send_request(pack_request(31, 12, 65535, 1, 0, 0));
        // out-of-range months while adding days and months, plus a plain month end
        send_request(pack_request(31, 13, 2020, 1, 0, 0));
        send_request(pack_request(31, 0, 1600, 40, 0, 0));
        send_request(pack_request(30, 4, 2021, 1, 0, 0));
        send_request(pack_request(10, 0, 2022, 0, 1, 0));
        send_request(pack_request(10, 14, 2022, 0, 1, 0));
        // month add does not clamp the day; overflow by months or by years; all three amounts
        send_request(pack_request(31, 1, 2023, 0, 1, 0));
        send_request(pack_request(1, 12, 65535, 0, 4095, 0));
        send_request(pack_request(1, 1, 65535, 0, 0, 65535));
        send_request(pack_request(5, 7, 1234, 400, 30, 12));
        // full-range amounts
        send_request(pack_request(1, 1, 2000, 65535, 0, 0));
        send_request(pack_request(31, 15, 65535, 65535, 4095, 65535));
        drain_dates();

        burst_left = 0;
        for (item_count = 0; item_count < RANDOM_ITEMS; item_count++) begin
            if (item_count % 250 == 249) begin
                drain_dates();
            end else if (burst_left == 0) begin
                s_valid <= 1'b0;
                gap_max = ($urandom_range(0, 9) == 0) ? 300 : 30;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            if (burst_left > 0)
                burst_left--;
            send_request(random_request());
        end

        drain_dates();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
